// ===== src/ksm_pkg.sv =====
// Shared types and codes for the KMP stream matcher.
// Used by ksm_front, ksm_engine and kmp_stream_matcher_top; no dependencies.
package ksm_pkg;

  // Input op codes (s_tuser)
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TEXT   = 2'd2;

  // Result status codes (m_tuser)
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd0;
  localparam logic [1:0] STATUS_FOUND     = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;

  localparam logic [15:0] POS_SAT = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       last;
  } ksm_cmd_t;

endpackage

// ===== src/ksm_front.sv =====
// Front end: accepts stream items, classifies the op and queues commands.
// Depends on ksm_pkg.
module ksm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // data_byte
  input  logic [1:0]        s_tuser,   // op
  input  logic              s_tlast,   // last
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output ksm_pkg::ksm_cmd_t cmd
);

  ksm_pkg::ksm_cmd_t queue [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  ksm_pkg::ksm_cmd_t in_cmd;
  logic              keep;
  logic              push;
  logic              pop;

  always_comb begin
    in_cmd.data = s_tdata;
    in_cmd.last = s_tlast;
    in_cmd.kind = ksm_pkg::CMD_CLEAR;
    keep        = 1'b1;
    unique case (s_tuser)
      ksm_pkg::OP_CLEAR:  in_cmd.kind = ksm_pkg::CMD_CLEAR;
      ksm_pkg::OP_APPEND: in_cmd.kind = ksm_pkg::CMD_APPEND;
      ksm_pkg::OP_TEXT:   in_cmd.kind = ksm_pkg::CMD_TEXT;
      default:            keep = 1'b0;  // undefined op: drop
    endcase
  end

  assign s_tready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = queue[rd_ptr];
  assign push      = s_tvalid && s_tready && keep;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== src/ksm_engine.sv =====
// Back end: pattern and failure-table memories, failure-link walker and result register.
// Depends on ksm_pkg.
module ksm_engine #(
  parameter int PATTERN_MAX = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  ksm_pkg::ksm_cmd_t cmd,
  input  logic [15:0]       start_offset,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [15:0]       out_position
);

  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int TI_W  = $clog2(65536 + PATTERN_MAX);
  localparam int PW    = TI_W + 2;
  localparam logic [TI_W-1:0]  INDEX_CAP = TI_W'(65535 + PATTERN_MAX);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(PATTERN_MAX);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SEED  = 3'b010,
    S_CHECK = 3'b100
  } state_t;

  state_t            state;
  logic [LEN_W-1:0]  pat_len;
  logic              overflow;
  logic [LEN_W-1:0]  progress;
  logic [TI_W-1:0]   text_index;
  logic              search_done;
  logic [IDX_W-1:0]  walk;
  logic [7:0]        byte_q;
  logic              last_q;
  logic              is_append;

  logic [7:0]        pattern_store [PATTERN_MAX];
  logic [IDX_W-1:0]  failure_table [PATTERN_MAX];
  logic [7:0]        ps_q;
  logic [IDX_W-1:0]  ft_q;

  logic [IDX_W-1:0]  rd_base;
  logic              mem_we;
  logic [IDX_W-1:0]  wr_addr;
  logic [7:0]        ps_wdata;
  logic [IDX_W-1:0]  ft_wdata;

  logic              hit;
  logic              walk_end;
  logic [LEN_W-1:0]  res;
  logic [PW-1:0]     match_sum;
  logic [15:0]       match_pos;
  logic [TI_W-1:0]   text_index_inc;

  assign hit      = (ps_q == byte_q);
  assign walk_end = hit || (walk == '0);
  assign res      = hit ? (LEN_W'(walk) + LEN_W'(1)) : '0;

  assign match_sum = PW'(start_offset) + PW'(text_index) + PW'(1) - PW'(pat_len);
  assign match_pos = (match_sum > PW'(ksm_pkg::POS_SAT)) ? ksm_pkg::POS_SAT
                                                          : match_sum[15:0];
  assign text_index_inc = (text_index < INDEX_CAP) ? text_index + TI_W'(1) : text_index;

  assign cmd_ready = (state == S_IDLE) &&
                     (cmd.kind != ksm_pkg::CMD_TEXT || !out_valid || out_ready);

  // Read addresses: the next walk position and its failure link
  always_comb begin
    if (state == S_IDLE) begin
      rd_base = (cmd.kind == ksm_pkg::CMD_TEXT) ? progress[IDX_W-1:0] : pat_len[IDX_W-1:0];
    end else begin
      rd_base = ft_q;
    end
  end

  always_comb begin
    mem_we   = 1'b0;
    wr_addr  = pat_len[IDX_W-1:0];
    ps_wdata = byte_q;
    ft_wdata = res[IDX_W-1:0];
    if (state == S_IDLE) begin
      // first pattern byte: border is empty
      mem_we   = cmd_valid && cmd_ready && (cmd.kind == ksm_pkg::CMD_APPEND) &&
                 (pat_len == '0);
      ps_wdata = cmd.data;
      ft_wdata = '0;
    end else if (state == S_CHECK) begin
      mem_we = is_append && walk_end;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pattern_store[wr_addr] <= ps_wdata;
      failure_table[wr_addr] <= ft_wdata;
    end
    ps_q <= pattern_store[rd_base];
    ft_q <= failure_table[rd_base - IDX_W'(1)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pat_len     <= '0;
      overflow    <= 1'b0;
      progress    <= '0;
      text_index  <= '0;
      search_done <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            byte_q    <= cmd.data;
            last_q    <= cmd.last;
            is_append <= (cmd.kind == ksm_pkg::CMD_APPEND);
            walk      <= rd_base;
            unique case (cmd.kind)
              ksm_pkg::CMD_CLEAR: begin
                pat_len     <= '0;
                overflow    <= 1'b0;
                progress    <= '0;
                text_index  <= '0;
                search_done <= 1'b0;
              end
              ksm_pkg::CMD_APPEND: begin
                progress    <= '0;
                text_index  <= '0;
                search_done <= 1'b0;
                priority if (pat_len >= LEN_MAX) begin
                  overflow <= 1'b1;
                end else if (pat_len == '0) begin
                  pat_len <= LEN_W'(1);
                end else begin
                  state <= S_SEED;
                end
              end
              ksm_pkg::CMD_TEXT: begin
                if (!search_done && !overflow && pat_len != '0) begin
                  state <= S_CHECK;
                end else begin
                  if (!search_done) begin
                    out_valid    <= 1'b1;
                    out_status   <= overflow ? ksm_pkg::STATUS_TOO_LONG : ksm_pkg::STATUS_FOUND;
                    out_position <= overflow ? 16'd0 : start_offset;
                    search_done  <= 1'b1;
                  end
                  text_index <= text_index_inc;
                  if (cmd.last) begin
                    progress    <= '0;
                    text_index  <= '0;
                    search_done <= 1'b0;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_SEED: begin
          // ft_q holds the border of the previous prefix
          walk  <= ft_q;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (!walk_end) begin
            walk <= ft_q;  // fall back along the failure link
          end else begin
            state <= S_IDLE;
            if (is_append) begin
              pat_len <= pat_len + LEN_W'(1);
            end else begin
              progress   <= res;
              text_index <= text_index_inc;
              if (res == pat_len) begin
                out_valid    <= 1'b1;
                out_status   <= ksm_pkg::STATUS_FOUND;
                out_position <= match_pos;
                search_done  <= 1'b1;
              end else if (last_q) begin
                out_valid    <= 1'b1;
                out_status   <= ksm_pkg::STATUS_NOT_FOUND;
                out_position <= 16'd0;
              end
              if (last_q) begin
                progress    <= '0;
                text_index  <= '0;
                search_done <= 1'b0;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/kmp_stream_matcher_top.sv =====
// Top level of the KMP stream matcher: start_offset register, front queue and engine.
// Depends on ksm_pkg, ksm_front and ksm_engine.
// Text byte: idle, then the check state, which follows one failure link per walker step.
// Append: the first byte is written from idle; later bytes pass idle, seed and the check walk.
// Clear and already-decided text bytes are handled in idle. The result is registered as the walk ends.
// Reset clears control state; pattern and failure memories stay undefined, no clearing pass.
module kmp_stream_matcher_top #(
  parameter int PATTERN_MAX = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_tuser,   // [1:0] op
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] position
  output logic [1:0]  m_tuser,   // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic              cmd_valid;
  logic              cmd_ready;
  ksm_pkg::ksm_cmd_t cmd;
  logic [15:0]       start_offset;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      start_offset <= cfg_data;
    end
  end

  ksm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  ksm_engine #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .start_offset (start_offset),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_status   (m_tuser),
    .out_position (m_tdata)
  );

endmodule
